// ----- design/bmfr_pkg.sv -----
// Package for the box mean filter: payload structs, lane control struct,
// command and register codes, and fixed field widths. No dependencies.
package bmfr_pkg;

  localparam int SampleW  = 8;
  localparam int NumCh    = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_WIDTH    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RADIUS   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_CHANNELS = 2'd3;

  localparam logic [10:0] RST_WIDTH    = 11'd640;
  localparam logic [10:0] RST_HEIGHT   = 11'd480;
  localparam logic [2:0]  RST_RADIUS   = 3'd1;
  localparam logic [1:0]  RST_CHANNELS = 2'd1;

  typedef struct packed {
    logic               cmd;
    logic [SampleW-1:0] sample_c0;
    logic [SampleW-1:0] sample_c1;
    logic [SampleW-1:0] sample_c2;
  } pix_in_t;

  typedef struct packed {
    logic [SampleW-1:0] mean_c0;
    logic [SampleW-1:0] mean_c1;
    logic [SampleW-1:0] mean_c2;
    logic               last_of_frame;
  } pix_out_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic acc_clear;
    logic acc_en;
    logic div_load;
    logic div_step;
  } lane_ctl_t;

endpackage

// ----- design/bmfr_lane.sv -----
// One channel lane: row store memory, window accumulator and restoring divider.
// Depends on bmfr_pkg for the lane control struct and sample width.
module bmfr_lane import bmfr_pkg::*; #(
  parameter int AW = 14,
  parameter int SW = 16,
  parameter int DW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lane_ctl_t          ctl_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [SampleW-1:0] wr_data_i,
  input  logic [AW-1:0]      rd_addr_i,
  input  logic [DW-1:0]      divisor_i,
  output logic [SampleW-1:0] mean_o
);

  logic [SampleW-1:0] mem_q [2**AW];
  logic [SampleW-1:0] rd_data_q;
  logic [SW-1:0]      acc_q, acc_d;
  logic [DW:0]        rem_q, rem_d;
  logic [SW-1:0]      quot_q, quot_d;
  logic [DW:0]        shifted;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.acc_clear) begin
      acc_d = '0;
    end else if (ctl_i.acc_en) begin
      acc_d = acc_q + SW'(rd_data_q);
    end
  end

  // One quotient bit per step, MSB first.
  assign shifted = {rem_q[DW-1:0], quot_q[SW-1]};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    if (ctl_i.div_load) begin
      rem_d  = '0;
      quot_d = acc_q;
    end else if (ctl_i.div_step) begin
      if (shifted >= {1'b0, divisor_i}) begin
        rem_d  = shifted - {1'b0, divisor_i};
        quot_d = {quot_q[SW-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
    end else begin
      acc_q  <= acc_d;
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign mean_o = quot_q[SampleW-1:0];

endmodule

// ----- design/bmfr_merge.sv -----
// Merge stage: gathers the lane quotients, masks unused channels and holds
// the result item in the output register. Depends on bmfr_pkg.
module bmfr_merge import bmfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [SampleW-1:0] mean_i [NumCh],
  input  logic [1:0]         ch_used_i,
  input  logic               last_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pix_out_t           out_data_o
);

  logic     valid_q, valid_d;
  pix_out_t data_q, data_d;

  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
      data_d.mean_c0       = mean_i[0];
      data_d.mean_c1       = (ch_used_i > 2'd1) ? mean_i[1] : '0;
      data_d.mean_c2       = (ch_used_i > 2'd2) ? mean_i[2] : '0;
      data_d.last_of_frame = last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- design/box_mean_filter_replicate_core.sv -----
// Top level of the streaming box mean filter with replicated borders.
// Depends on bmfr_pkg, bmfr_lane and bmfr_merge.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o   | in_data_i  (pix_in_t)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (pix_out_t)
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item at a time. An item that yields a result makes (2r+1)^2 window reads
// through the single read port of each lane memory, then a 16-step restoring
// divide with the default parameters. An item with no result goes from the
// window check straight back to idle. A stalled output holds the result in the
// merge register and the sequencer waits in its emit step. Reset clears counters
// and valid flags and loads the register defaults; the row store is not cleared.
module box_mean_filter_replicate_core import bmfr_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pix_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pix_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int CW    = $clog2(MAX_WIDTH);          // column index
  localparam int WW    = $clog2(MAX_WIDTH + 1);      // width value
  localparam int HW    = $clog2(MAX_HEIGHT + 1);     // row counter, holds height
  localparam int RB    = $clog2(MAX_RADIUS + 1);
  localparam int KW    = $clog2(2 * MAX_RADIUS + 1); // window offset
  localparam int SB    = $clog2(2 * MAX_RADIUS + 2); // row slot bits
  localparam int AW    = SB + CW;
  localparam int SW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int DW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int DCW   = $clog2(SW + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_RUN   = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [10:0] cfg_w_q, cfg_h_q;
  logic [2:0]  cfg_r_q;
  logic [1:0]  cfg_ch_q;
  logic        cfg_fire;

  // Frame counters.
  logic [HW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;

  // Window walk and divide counters.
  logic [KW-1:0]  wx_q, wx_d, wy_q, wy_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic           rvalid_q;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [RB-1:0] r_eff;
  logic [1:0]    ch_eff;
  logic [KW-1:0] two_r;
  logic [KW-1:0] side;
  logic [DW-1:0] divisor;

  logic          in_fire, pix_write, win_ready, is_last, merge_ready, merge_load;
  logic [HW:0]   need_r_sum, need_r;
  logic [CW:0]   need_c_sum, need_c;
  logic [HW:0]   ty, y_sel;
  logic [CW:0]   tx, x_sel;
  logic [AW-1:0] wr_addr, rd_addr;
  lane_ctl_t     ctl;
  logic [SampleW-1:0] lane_wr [NumCh];
  logic [SampleW-1:0] lane_mean [NumCh];

  // Effective register values, saturated to their legal ranges.
  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_h_q);
    end
    if (32'(cfg_r_q) > MAX_RADIUS) begin
      r_eff = RB'(MAX_RADIUS);
    end else begin
      r_eff = RB'(cfg_r_q);
    end
    ch_eff = (cfg_ch_q == 2'd0) ? 2'd1 : cfg_ch_q;
  end

  assign two_r   = KW'({r_eff, 1'b0});
  assign side    = two_r + KW'(1);
  assign divisor = DW'(DW'(side) * DW'(side));

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q  <= RST_WIDTH;
      cfg_h_q  <= RST_HEIGHT;
      cfg_r_q  <= RST_RADIUS;
      cfg_ch_q <= RST_CHANNELS;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        CFG_WIDTH:    cfg_w_q  <= cfg_data_i;
        CFG_HEIGHT:   cfg_h_q  <= cfg_data_i;
        CFG_RADIUS:   cfg_r_q  <= cfg_data_i[2:0];
        CFG_CHANNELS: cfg_ch_q <= cfg_data_i[1:0];
        default:      cfg_w_q  <= cfg_w_q;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign pix_write  = in_fire && (in_data_i.cmd == CMD_PIXEL) && (in_row_q < h_eff);

  // Row slot is the low bits of the row number; enough slots for 2r+2 live rows.
  assign wr_addr = {in_row_q[SB-1:0], in_col_q};

  // The newest pixel the next output needs, clamped to the frame.
  always_comb begin
    need_r_sum = (HW+1)'(out_row_q) + (HW+1)'(r_eff);
    need_r     = (need_r_sum > (HW+1)'(h_eff - HW'(1))) ? (HW+1)'(h_eff - HW'(1)) : need_r_sum;
    need_c_sum = (CW+1)'(out_col_q) + (CW+1)'(r_eff);
    need_c     = (need_c_sum > (CW+1)'(w_eff - WW'(1))) ? (CW+1)'(w_eff - WW'(1)) : need_c_sum;
    win_ready  = (out_row_q < h_eff) &&
                 ((need_r < (HW+1)'(in_row_q)) ||
                  ((need_r == (HW+1)'(in_row_q)) && (need_c < (CW+1)'(in_col_q))));
  end

  // Window coordinates with edge replication.
  always_comb begin
    ty = (HW+1)'(out_row_q) + (HW+1)'(wy_q);
    y_sel = (ty < (HW+1)'(r_eff)) ? '0 : ty - (HW+1)'(r_eff);
    if (y_sel >= (HW+1)'(h_eff)) begin
      y_sel = (HW+1)'(h_eff - HW'(1));
    end
    tx = (CW+1)'(out_col_q) + (CW+1)'(wx_q);
    x_sel = (tx < (CW+1)'(r_eff)) ? '0 : tx - (CW+1)'(r_eff);
    if (x_sel >= (CW+1)'(w_eff)) begin
      x_sel = (CW+1)'(w_eff - WW'(1));
    end
  end

  assign rd_addr = {y_sel[SB-1:0], x_sel[CW-1:0]};
  assign is_last = (out_row_q == h_eff - HW'(1)) && ((CW+1)'(out_col_q) == (CW+1)'(w_eff - WW'(1)));
  assign merge_load = (state_q == ST_EMIT) && merge_ready;

  // Sequencer and counters.
  always_comb begin
    state_d   = state_q;
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    wx_d      = wx_q;
    wy_d      = wy_q;
    dcnt_d    = dcnt_q;
    ctl       = '0;
    ctl.wr_en = pix_write;
    ctl.acc_en = rvalid_q;

    if (pix_write) begin
      if ((CW+1)'(in_col_q) + (CW+1)'(1) >= (CW+1)'(w_eff)) begin
        in_col_d = '0;
        in_row_d = in_row_q + HW'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        wx_d = '0;
        wy_d = '0;
        ctl.acc_clear = 1'b1;
        state_d = win_ready ? ST_RUN : ST_IDLE;
      end
      ST_RUN: begin
        ctl.rd_en = 1'b1;
        if (wx_q == two_r) begin
          wx_d = '0;
          if (wy_q == two_r) begin
            state_d = ST_DRAIN;
          end else begin
            wy_d = wy_q + KW'(1);
          end
        end else begin
          wx_d = wx_q + KW'(1);
        end
      end
      ST_DRAIN: begin
        dcnt_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_load = (dcnt_q == '0);
        ctl.div_step = (dcnt_q != '0);
        if (dcnt_q == DCW'(SW)) begin
          state_d = ST_EMIT;
        end else begin
          dcnt_d = dcnt_q + DCW'(1);
        end
      end
      ST_EMIT: begin
        if (merge_ready) begin
          state_d = ST_IDLE;
          if (is_last) begin
            // End of frame: restart all position counters.
            in_row_d  = '0;
            in_col_d  = '0;
            out_row_d = '0;
            out_col_d = '0;
          end else if ((CW+1)'(out_col_q) + (CW+1)'(1) >= (CW+1)'(w_eff)) begin
            out_col_d = '0;
            out_row_d = out_row_q + HW'(1);
          end else begin
            out_col_d = out_col_q + CW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Any register write abandons the frame.
    if (cfg_fire) begin
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      wx_q      <= '0;
      wy_q      <= '0;
      dcnt_q    <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      wx_q      <= wx_d;
      wy_q      <= wy_d;
      dcnt_q    <= dcnt_d;
      rvalid_q  <= ctl.rd_en;
    end
  end

  assign lane_wr[0] = in_data_i.sample_c0;
  assign lane_wr[1] = in_data_i.sample_c1;
  assign lane_wr[2] = in_data_i.sample_c2;

  for (genvar c = 0; c < NumCh; c++) begin : g_lane
    bmfr_lane #(
      .AW (AW),
      .SW (SW),
      .DW (DW)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .wr_addr_i (wr_addr),
      .wr_data_i (lane_wr[c]),
      .rd_addr_i (rd_addr),
      .divisor_i (divisor),
      .mean_o    (lane_mean[c])
    );
  end

  bmfr_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (merge_load),
    .mean_i      (lane_mean),
    .ch_used_i   (ch_eff),
    .last_i      (is_last),
    .ready_o     (merge_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_CHECK)
    else $error("accepted item did not enter the window check");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW+1)'(in_col_q) < (CW+1)'(w_eff))
    else $error("input column beyond frame width");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_row_q <= in_row_q)
    else $error("output row ahead of input row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> out_row_q < h_eff)
    else $error("window walk for a row outside the frame");
`endif

endmodule
